// File: src/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg
// shared widths, counter types and the saturating counter update
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int ADDR_W  = 15;
    localparam int INDEX_W = 15;
    localparam int HIST_W  = 15;

    typedef logic [1:0]         t_ctr;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [HIST_W-1:0]  t_hist;

    // bimodal and selector share an index, so they share a memory word
    typedef struct packed {
        t_ctr sel;
        t_ctr bim;
    } t_bs_entry;

    localparam t_ctr CTR_STRONG_TAKEN = 2'd3;
    localparam t_ctr CTR_STRONG_BIM   = 2'd0;
    localparam t_ctr CTR_MAX          = 2'd3;
    localparam t_ctr CTR_MIN          = 2'd0;

    function automatic t_ctr sat_move(input t_ctr c, input logic up);
        t_ctr r;
        r = c;
        if (up) begin
            if (c != CTR_MAX) r = c + 2'd1;
        end else begin
            if (c != CTR_MIN) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

// File: src/tbp_if.sv
// ----------------------------------------------------------------------------
// tbp_br_if / tbp_pred_if
// valid/ready channels for resolved branches and prediction results
// ----------------------------------------------------------------------------
interface tbp_br_if import tbp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_addr branch_address;
    logic  taken;

    modport source (output valid, output branch_address, output taken, input ready);
    modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface tbp_pred_if;
    logic valid;
    logic ready;
    logic predicted_taken;
    logic used_gshare;
    logic mispredicted;

    modport source (output valid, output predicted_taken, output used_gshare,
                    output mispredicted, input ready);
    modport sink   (input valid, input predicted_taken, input used_gshare,
                    input mispredicted, output ready);
endinterface

// File: src/tbp_ram.sv
// ----------------------------------------------------------------------------
// tbp_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tbp_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 2
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/tournament_branch_predictor_core.sv
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core
// bimodal + gshare predictor with per-address selector, predict then train
// ----------------------------------------------------------------------------
//  channel  | dir | signals                                        | role
//  i_br     | in  | valid ready branch_address taken               | resolved branch
//  o_pred   | out | valid ready predicted_taken used_gshare mispr. | prediction result
//
//  each transaction: memory read issued on accept, then modify and write back in S_UPDATE
//  after reset a clearing pass writes all 32768 entries, no input taken
//  the result sits in an output register, so a new branch is accepted while it waits
//  a full output register with ready low holds the write-back stage
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core import tbp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tbp_br_if.sink       i_br,
    tbp_pred_if.source   o_pred
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_UPDATE} t_state;

    t_state    r_state;
    t_index    r_clr_idx;
    t_index    r_idx;
    t_index    r_gidx;
    logic      r_taken;
    t_hist     r_hist;
    logic      r_out_valid;
    logic      r_out_pred;
    logic      r_out_gsh;
    logic      r_out_mis;

    logic      accept;
    logic      upd;
    t_index    in_idx;
    t_index    in_gidx;

    t_index    bs_rd_addr;
    t_index    g_rd_addr;
    t_bs_entry bs_rd;
    t_ctr      g_rd;
    logic      bs_we;
    logic      g_we;
    t_index    bs_wr_addr;
    t_index    g_wr_addr;
    t_bs_entry bs_wr;
    t_ctr      g_wr;

    logic      pred_bim;
    logic      pred_gsh;
    logic      use_gsh;
    logic      pred;
    t_bs_entry n_bs;
    t_ctr      n_g;
    t_hist     n_hist;

    assign i_br.ready = (r_state == S_IDLE);
    assign accept     = i_br.valid && i_br.ready;
    assign upd        = (r_state == S_UPDATE) && (!r_out_valid || o_pred.ready);

    assign in_idx  = INDEX_W'(i_br.branch_address);
    assign in_gidx = INDEX_W'(i_br.branch_address) ^ INDEX_W'(r_hist);

    // re-read the held entry while stalled, nothing is written in between
    assign bs_rd_addr = accept ? in_idx  : r_idx;
    assign g_rd_addr  = accept ? in_gidx : r_gidx;

    always_comb begin
        pred_bim = bs_rd.bim[1];
        pred_gsh = g_rd[1];
        use_gsh  = bs_rd.sel[1];
        pred     = use_gsh ? pred_gsh : pred_bim;

        n_bs.bim = sat_move(bs_rd.bim, r_taken);
        n_bs.sel = bs_rd.sel;
        if (pred_bim != pred_gsh) begin
            n_bs.sel = sat_move(bs_rd.sel, pred_gsh == r_taken);
        end
        n_g    = sat_move(g_rd, r_taken);
        n_hist = HIST_W'({r_hist, r_taken});
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            bs_we      = 1'b1;
            g_we       = 1'b1;
            bs_wr_addr = r_clr_idx;
            g_wr_addr  = r_clr_idx;
            bs_wr.sel  = CTR_STRONG_BIM;
            bs_wr.bim  = CTR_STRONG_TAKEN;
            g_wr       = CTR_STRONG_TAKEN;
        end else begin
            bs_we      = upd;
            g_we       = upd;
            bs_wr_addr = r_idx;
            g_wr_addr  = r_gidx;
            bs_wr      = n_bs;
            g_wr       = n_g;
        end
    end

    tbp_ram #(.ADDR_W(INDEX_W), .DATA_W($bits(t_bs_entry))) u_bs_ram (
        .i_clk     (i_clk),
        .i_we      (bs_we),
        .i_wr_addr (bs_wr_addr),
        .i_wr_data (bs_wr),
        .i_rd_addr (bs_rd_addr),
        .o_rd_data (bs_rd)
    );

    tbp_ram #(.ADDR_W(INDEX_W), .DATA_W($bits(t_ctr))) u_g_ram (
        .i_clk     (i_clk),
        .i_we      (g_we),
        .i_wr_addr (g_wr_addr),
        .i_wr_data (g_wr),
        .i_rd_addr (g_rd_addr),
        .o_rd_data (g_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_hist      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (upd) begin
                        r_state <= S_IDLE;
                        r_hist  <= n_hist;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase

            if (upd) begin
                r_out_valid <= 1'b1;
            end else if (o_pred.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (accept) begin
            r_idx   <= in_idx;
            r_gidx  <= in_gidx;
            r_taken <= i_br.taken;
        end
        if (upd) begin
            r_out_pred <= pred;
            r_out_gsh  <= use_gsh;
            r_out_mis  <= pred != r_taken;
        end
    end

    assign o_pred.valid           = r_out_valid;
    assign o_pred.predicted_taken = r_out_pred;
    assign o_pred.used_gshare     = r_out_gsh;
    assign o_pred.mispredicted    = r_out_mis;

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_br.ready)
        else $error("branch accepted during table clear");

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_UPDATE))
        else $error("accepted branch did not enter update");

    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |=> (r_hist[0] == $past(r_taken)) && o_pred.valid)
        else $error("history or result not updated on write-back");
`endif

endmodule
